[src/i2c_bus_sniffer_decoder_assert.svh]
// assertion macros shared by the sniffer modules
// they expect clk and rst_n in the module that uses them
`ifndef I2C_BUS_SNIFFER_DECODER_ASSERT_SVH
`define I2C_BUS_SNIFFER_DECODER_ASSERT_SVH

// same-cycle implication
`define I2CBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define I2CBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/i2cbs_pkg.sv]
`timescale 1ns / 1ps
package i2cbs_pkg;

  localparam int TIMER_W   = 32;
  localparam int TIMEOUT_W = 32;
  localparam int CMP_W     = (TIMER_W > TIMEOUT_W) ? TIMER_W : TIMEOUT_W;

  localparam logic [3:0]           FRAME_BITS    = 4'd9;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1500);

  typedef enum logic [2:0] {
    EVT_START   = 3'd0,
    EVT_STOP    = 3'd1,
    EVT_ADDRESS = 3'd2,
    EVT_DATA    = 3'd3,
    EVT_TIMEOUT = 3'd4,
    EVT_STRAY   = 3'd5
  } evt_t;

  typedef struct packed {
    evt_t       event_res;
    logic [7:0] value;
    logic       read_not_write;
    logic       acked;
    logic [3:0] bits_received;
    logic       incomplete_frame;
    logic       scl_level;
    logic       sda_level;
  } res_t;

endpackage

[src/i2cbs_core.sv]
`timescale 1ns / 1ps
`include "i2c_bus_sniffer_decoder_assert.svh"
module i2cbs_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  logic                           scl,
  input  logic                           sda,
  input  logic                           cfg_we,
  input  logic [i2cbs_pkg::TIMEOUT_W-1:0] cfg_data,
  output logic                           res_vld,
  output i2cbs_pkg::res_t                res
);
  import i2cbs_pkg::*;

  logic                 prev_scl_r, prev_sda_r;
  logic [3:0]           bp_r, bp_nxt;
  logic [7:0]           sb_r, sb_nxt;
  logic                 rw_r, rw_nxt;
  logic                 exp_r, exp_nxt;
  logic [TIMER_W-1:0]   idle_r, idle_nxt, idle_inc;
  logic [TIMEOUT_W-1:0] timeout_r;

  logic start, stop, sclk, incomplete, restart;

  assign start      = prev_scl_r & scl & prev_sda_r & ~sda;
  assign stop       = prev_scl_r & scl & ~prev_sda_r & sda;
  assign sclk       = ~prev_scl_r & scl;
  assign incomplete = (bp_r >= 4'd2) && (bp_r <= 4'd8);
  assign idle_inc   = (idle_r != {TIMER_W{1'b1}}) ? idle_r + TIMER_W'(1) : idle_r;

  always_comb begin
    bp_nxt   = bp_r;
    sb_nxt   = sb_r;
    rw_nxt   = rw_r;
    exp_nxt  = exp_r;
    idle_nxt = idle_inc;
    restart  = 1'b0;
    res_vld  = 1'b0;
    res      = '0;
    if (start) begin
      res.event_res        = EVT_START;
      res.incomplete_frame = incomplete;
      bp_nxt               = FRAME_BITS;
      sb_nxt               = '0;
      exp_nxt              = 1'b1;
      res_vld              = 1'b1;
    end else if (stop) begin
      res.event_res        = EVT_STOP;
      res.incomplete_frame = incomplete;
      if (incomplete) begin
        bp_nxt = '0;
      end
      sb_nxt  = '0;
      res_vld = 1'b1;
    end else if (sclk) begin
      if (bp_r == 4'd0 || bp_r > FRAME_BITS) begin
        res.event_res = EVT_STRAY;
        res_vld       = 1'b1;
      end else begin
        bp_nxt = bp_r - 4'd1;
        if (bp_nxt == 4'd0) begin
          res.event_res      = exp_r ? EVT_ADDRESS : EVT_DATA;
          res.value          = sb_r;
          res.read_not_write = exp_r & rw_r;
          res.acked          = ~sda;
          res_vld            = 1'b1;
          restart            = 1'b1;
        end else if (bp_nxt == 4'd1 && exp_r) begin
          rw_nxt = sda;
        end else begin
          sb_nxt = {sb_r[6:0], sda};
        end
      end
    end
    if (!res_vld && (CMP_W'(idle_inc) >= CMP_W'(timeout_r))) begin
      res.event_res     = EVT_TIMEOUT;
      res.value         = sb_nxt;
      res.bits_received = (bp_nxt <= FRAME_BITS) ? FRAME_BITS - bp_nxt : 4'd0;
      res.scl_level     = scl;
      res.sda_level     = sda;
      res_vld           = 1'b1;
      restart           = 1'b1;
    end
    if (restart) begin
      sb_nxt   = '0;
      bp_nxt   = FRAME_BITS;
      exp_nxt  = 1'b0;
      idle_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_scl_r <= 1'b1;
      prev_sda_r <= 1'b1;
      bp_r       <= '0;
      sb_r       <= '0;
      rw_r       <= 1'b0;
      exp_r      <= 1'b0;
      idle_r     <= '0;
      timeout_r  <= TIMEOUT_RESET;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_data;
      end
      if (step_en) begin
        prev_scl_r <= scl;
        prev_sda_r <= sda;
        bp_r       <= bp_nxt;
        sb_r       <= sb_nxt;
        rw_r       <= rw_nxt;
        exp_r      <= exp_nxt;
        idle_r     <= idle_nxt;
      end
    end
  end

  `I2CBS_ASSERT_IMP(a_bp_range, 1'b1, bp_r <= FRAME_BITS, "bits pending out of range")
  `I2CBS_ASSERT_NXT(a_start_arms, step_en && start, exp_r && bp_r == FRAME_BITS, "start did not arm frame")
  `I2CBS_ASSERT_NXT(a_frame_restart, step_en && res_vld && (res.event_res == EVT_ADDRESS || res.event_res == EVT_DATA || res.event_res == EVT_TIMEOUT), idle_r == '0 && bp_r == FRAME_BITS && !exp_r, "frame not restarted")

endmodule

[src/i2cbs_out_reg.sv]
`timescale 1ns / 1ps
module i2cbs_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic            res_vld,
  input  i2cbs_pkg::res_t res,
  input  logic            out_tready,
  output logic            can_load,
  output logic            out_tvalid,
  output i2cbs_pkg::res_t out_res
);
  import i2cbs_pkg::*;

  logic valid_r;
  res_t res_r;

  assign can_load   = ~valid_r | out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load & res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load && res_vld) begin
      res_r <= res;
    end
  end

endmodule

[src/i2c_bus_sniffer_decoder.sv]
`timescale 1ns / 1ps
// Passive I2C monitor: one SCL/SDA sample is taken per request on the input
// stream, one every cycle at full rate while the input is not stalled. Each
// sample yields at most one result (start, stop, address byte, data byte,
// timeout dump or stray bit). The sample is first registered in the input
// register; its decode is then registered in the result register and held
// there until it is taken from the output stream. Backpressure on the output
// stalls the input only when both registers are full.
`include "i2c_bus_sniffer_decoder_assert.svh"
module i2c_bus_sniffer_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // scl, sda
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // value[7:0], read_not_write, acked,
                                                      // bits_received[3:0], incomplete_frame,
                                                      // scl_level, sda_level
  output logic [2:0]                      out_tuser,  // event_res
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [i2cbs_pkg::TIMEOUT_W-1:0] cfg_data
);
  import i2cbs_pkg::*;

  logic s1_valid_r, s1_scl_r, s1_sda_r;
  logic can_load, step_en, res_vld;
  res_t res, out_res;

  assign step_en   = s1_valid_r & can_load;
  assign in_tready = ~s1_valid_r | can_load;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_scl_r <= in_tdata[0];
      s1_sda_r <= in_tdata[1];
    end
  end

  i2cbs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .scl      (s1_scl_r),
    .sda      (s1_sda_r),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .res_vld  (res_vld),
    .res      (res)
  );

  i2cbs_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en),
    .res_vld    (res_vld),
    .res        (res),
    .out_tready (out_tready),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_res    (out_res)
  );

  assign out_tuser = out_res.event_res;
  assign out_tdata = {7'd0, out_res.sda_level, out_res.scl_level, out_res.incomplete_frame,
                      out_res.bits_received, out_res.acked, out_res.read_not_write,
                      out_res.value};

  `I2CBS_ASSERT_IMP(a_stall_cause, !in_tready, s1_valid_r && !can_load, "stall without cause")
  `I2CBS_ASSERT_NXT(a_step_moves, step_en && res_vld, out_tvalid, "result lost")

endmodule
